/* src/atr_pkg.sv */
// Shared types and constants of the airspeed / temperature readout.
// Holds the fixed-point airspeed constants, queue sizing and state encodings.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package atr_pkg;

	localparam int SAMPLE_BITS    = 10;
	localparam int RELOAD_BITS    = 8;
	localparam int OFFSET_BITS    = 10;
	localparam int CFG_DATA_BITS  = 10;
	localparam int CFG_INDEX_BITS = 1;
	localparam int VAL_BITS       = 11;
	localparam int DIGIT_BITS     = 4;
	localparam int NUM_DIGITS     = 4;
	localparam int DIG_IDX_BITS   = $clog2(NUM_DIGITS);

	localparam logic [RELOAD_BITS-1:0] RELOAD_RESET = RELOAD_BITS'(10);
	localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = OFFSET_BITS'(518);
	localparam logic [VAL_BITS-1:0]    VAL_MAX      = '1;

	// queue between front and back
	localparam int FIFO_DEPTH    = 2;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	// temperature path width: doubled difference of sample and offset
	localparam int TEMP_BITS = ((SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS) + 1;

	// airspeed: q = floor(K * d / DIV), d = 10*s - 2516, result isqrt(q)
	localparam int SPEED_MIN_SAMPLE = 252;
	localparam int SPEED_BIAS       = 2516;
	localparam int D_MAX            = 10 * ((1 << SAMPLE_BITS) - 1) - SPEED_BIAS;
	localparam int DIFF_BITS        = $clog2(D_MAX + 1);

	localparam logic [63:0] SPEED_K   = 64'd1943846 * 64'd1943846 * 64'd98;
	localparam logic [63:0] SPEED_DIV = 64'd129000000000000;

	localparam logic [63:0] Q_MAX = SPEED_K * 64'(D_MAX) / SPEED_DIV;
	localparam int Q_BITS    = $clog2(Q_MAX + 64'd1);

	// q = (d * RECIP) >> RECIP_SHIFT; the truncation error of RECIP times D_MAX stays
	// below the smallest nonzero fraction of K * d / DIV, so the floor is exact
	localparam int RECIP_SHIFT   = 57;
	// K / DIV lies below four
	localparam int RECIP_BITS    = RECIP_SHIFT + 2;
	localparam logic [127:0] RECIP_WIDE = (128'(SPEED_K) << RECIP_SHIFT) / 128'(SPEED_DIV);
	localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_WIDE);
	localparam int RECIP_LO_BITS = 30;
	localparam int RECIP_HI_BITS = RECIP_BITS - RECIP_LO_BITS;
	localparam logic [RECIP_LO_BITS-1:0] RECIP_LO = RECIP[RECIP_LO_BITS-1:0];
	localparam logic [RECIP_HI_BITS-1:0] RECIP_HI = RECIP[RECIP_BITS-1:RECIP_LO_BITS];
	localparam int PROD_BITS = RECIP_BITS + DIFF_BITS;

	localparam int ROOT_BITS = (Q_BITS + 1) / 2;
	localparam int SQ_BITS   = 2 * ROOT_BITS;

	localparam int STEP_MAX  = (ROOT_BITS > NUM_DIGITS) ? ROOT_BITS : NUM_DIGITS;
	localparam int STEP_BITS = $clog2(STEP_MAX);

	// divide by ten through a reciprocal, exact for 16-bit operands
	localparam int DIV10_BITS  = 16;
	localparam int DIV10_SHIFT = 19;
	localparam logic [DIV10_BITS-1:0] DIV10_MUL = DIV10_BITS'(52429);

	typedef enum logic {
		OP_TICK,
		OP_BUTTON
	} op_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_TICK_RELOAD,
		REG_TEMP_OFFSET
	} reg_index_t;

	typedef struct packed {
		logic                   speed_mode;
		logic [SAMPLE_BITS-1:0] sample;
	} item_t;

	typedef struct packed {
		logic                                  mode;
		logic [VAL_BITS-1:0]                   value;
		logic                                  negative;
		logic [NUM_DIGITS-1:0][DIGIT_BITS-1:0] digits;
	} result_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_ADD,
		B_SQRT,
		B_DIGIT,
		B_OUT
	} back_state_t;

endpackage

/* src/atr_fifo.sv */
// Short register queue that carries classified items from front to back.
// Depends on atr_pkg for the item type and depth.
`timescale 1ns / 1ps

module atr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  atr_pkg::item_t wr_item,
	output logic           full,
	input  logic           rd_en,
	output atr_pkg::item_t rd_item,
	output logic           empty
);
	import atr_pkg::*;

	item_t                    entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] count_q;
	logic                     do_wr;
	logic                     do_rd;

	assign full    = (count_q == FIFO_CNT_BITS'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

/* src/atr_front.sv */
// Front end: accepts ticks and button events, runs the latch counter and mode.
// Pushes the mode and latched sample of each item into the queue; uses atr_pkg.
`timescale 1ns / 1ps

module atr_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  atr_pkg::op_t                       operation,
	input  logic [atr_pkg::SAMPLE_BITS-1:0]    sample,
	input  logic [atr_pkg::RELOAD_BITS-1:0]    tick_reload,
	input  logic                               fifo_full,
	output logic                               fifo_push,
	output atr_pkg::item_t                     fifo_item
);
	import atr_pkg::*;

	logic [RELOAD_BITS-1:0] tick_count_q;
	logic [SAMPLE_BITS-1:0] held_q;
	logic                   mode_q;
	logic [RELOAD_BITS-1:0] count_dec;
	logic                   latch;
	logic [SAMPLE_BITS-1:0] held_n;
	logic                   mode_n;

	assign fifo_push = push && !fifo_full;

	always_comb begin
		count_dec = tick_count_q - 1'b1;
		latch     = (operation == OP_TICK) && (count_dec == '0);
		held_n    = latch ? sample : held_q;
		mode_n    = (operation == OP_BUTTON) ? !mode_q : mode_q;
		fifo_item = '{speed_mode: mode_n, sample: held_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			held_q       <= '0;
			mode_q       <= 1'b1;
		end else if (fifo_push) begin
			if (operation == OP_TICK) begin
				// reload on the transaction that latches
				tick_count_q <= latch ? tick_reload : count_dec;
				held_q       <= held_n;
			end
			mode_q <= mode_n;
		end
	end

endmodule

/* src/atr_back.sv */
// Back end: turns a queued item into the display value and its decimal digits.
// Reciprocal multiplier pair, serial square root and digit splitter; uses atr_pkg.
`timescale 1ns / 1ps

module atr_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [atr_pkg::OFFSET_BITS-1:0] temp_offset,
	input  logic                            fifo_empty,
	input  atr_pkg::item_t                  fifo_item,
	output logic                            fifo_pop,
	input  logic                            pop,
	output logic                            empty,
	output atr_pkg::result_t                result
);
	import atr_pkg::*;

	back_state_t                        state_q;
	back_state_t                        state_d;
	logic                               mode_q;
	logic                               neg_q;
	logic [DIFF_BITS-1:0]               d_q;
	logic [RECIP_HI_BITS+DIFF_BITS-1:0] p_hi_q;
	logic [RECIP_LO_BITS+DIFF_BITS-1:0] p_lo_q;
	logic [SQ_BITS-1:0]                 x_q;
	logic [SQ_BITS-1:0]                 root_q;
	logic [SQ_BITS-1:0]                 one_q;
	logic [STEP_BITS-1:0]               step_q;
	logic [VAL_BITS-1:0]                val_q;
	logic [VAL_BITS-1:0]                work_q;
	logic [DIGIT_BITS-1:0]              dig_q [NUM_DIGITS];
	result_t                            out_q;
	logic                               out_valid_q;

	logic                               low_speed;
	logic [TEMP_BITS-1:0]               s_w;
	logic [TEMP_BITS-1:0]               o_w;
	logic                               t_neg;
	logic [TEMP_BITS-1:0]               t_diff;
	logic [TEMP_BITS-1:0]               t_mag;
	logic [VAL_BITS-1:0]                t_val;
	logic [SAMPLE_BITS+3:0]             s_ext;
	logic [SAMPLE_BITS+3:0]             d_full;
	logic [PROD_BITS-1:0]               n_full;
	logic [Q_BITS-1:0]                  quot_n;
	logic [SQ_BITS-1:0]                 trial;
	logic                               sq_ge;
	logic [SQ_BITS-1:0]                 root_n;
	logic [VAL_BITS-1:0]                root_val;
	logic [VAL_BITS+DIV10_BITS-1:0]     div10_prod;
	logic [VAL_BITS-1:0]                quot10;
	logic [VAL_BITS-1:0]                quot10_x10;
	logic [DIGIT_BITS-1:0]              digit;
	logic                               last_sqrt;
	logic                               last_digit;
	logic                               out_load;

	assign empty  = !out_valid_q;
	assign result = out_q;

	// classification of the item at the head of the queue
	always_comb begin
		low_speed = fifo_item.sample < SAMPLE_BITS'(SPEED_MIN_SAMPLE);
		s_w       = TEMP_BITS'(fifo_item.sample);
		o_w       = TEMP_BITS'(temp_offset);
		t_neg     = s_w < o_w;
		t_diff    = t_neg ? (o_w - s_w) : (s_w - o_w);
		t_mag     = t_diff << 1;
		t_val     = (t_mag > TEMP_BITS'(VAL_MAX)) ? VAL_MAX : VAL_BITS'(t_mag);
		s_ext     = (SAMPLE_BITS + 4)'(fifo_item.sample);
		d_full    = (s_ext << 3) + (s_ext << 1) - (SAMPLE_BITS + 4)'(SPEED_BIAS);
	end

	// datapath of the serial units
	always_comb begin
		n_full     = (PROD_BITS'(p_hi_q) << RECIP_LO_BITS) + PROD_BITS'(p_lo_q);
		quot_n     = Q_BITS'(n_full >> RECIP_SHIFT);
		trial      = root_q + one_q;
		sq_ge      = x_q >= trial;
		root_n     = sq_ge ? ((root_q >> 1) + one_q) : (root_q >> 1);
		root_val   = (root_n > SQ_BITS'(VAL_MAX)) ? VAL_MAX : VAL_BITS'(root_n);
		div10_prod = (VAL_BITS + DIV10_BITS)'(work_q) * (VAL_BITS + DIV10_BITS)'(DIV10_MUL);
		quot10     = VAL_BITS'(div10_prod >> DIV10_SHIFT);
		quot10_x10 = (quot10 << 3) + (quot10 << 1);
		digit      = DIGIT_BITS'(work_q - quot10_x10);
		last_sqrt  = step_q == STEP_BITS'(ROOT_BITS - 1);
		last_digit = step_q == STEP_BITS'(NUM_DIGITS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		fifo_pop = 1'b0;
		out_load = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!fifo_empty) begin
					fifo_pop = 1'b1;
					if (fifo_item.speed_mode && !low_speed) begin
						state_d = B_MUL;
					end else begin
						state_d = B_DIGIT;
					end
				end
			end
			B_MUL:   state_d = B_ADD;
			B_ADD:   state_d = B_SQRT;
			B_SQRT: begin
				if (last_sqrt) begin
					state_d = B_DIGIT;
				end
			end
			B_DIGIT: begin
				if (last_digit) begin
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				// hold until the output slot frees up
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				mode_q <= fifo_item.speed_mode;
				step_q <= '0;
				d_q    <= DIFF_BITS'(d_full);
				if (fifo_item.speed_mode) begin
					neg_q  <= 1'b0;
					val_q  <= '0;
					work_q <= '0;
				end else begin
					neg_q  <= t_neg;
					val_q  <= t_val;
					work_q <= t_val;
				end
			end
			B_MUL: begin
				p_hi_q <= (RECIP_HI_BITS + DIFF_BITS)'(d_q) *
					(RECIP_HI_BITS + DIFF_BITS)'(RECIP_HI);
				p_lo_q <= (RECIP_LO_BITS + DIFF_BITS)'(d_q) *
					(RECIP_LO_BITS + DIFF_BITS)'(RECIP_LO);
			end
			B_ADD: begin
				x_q    <= SQ_BITS'(quot_n);
				root_q <= '0;
				one_q  <= SQ_BITS'(1) << (SQ_BITS - 2);
				step_q <= '0;
			end
			B_SQRT: begin
				if (sq_ge) begin
					x_q <= x_q - trial;
				end
				root_q <= root_n;
				one_q  <= one_q >> 2;
				step_q <= step_q + 1'b1;
				if (last_sqrt) begin
					val_q  <= root_val;
					work_q <= root_val;
					step_q <= '0;
				end
			end
			B_DIGIT: begin
				dig_q[step_q[DIG_IDX_BITS-1:0]] <= digit;
				work_q <= quot10;
				step_q <= step_q + 1'b1;
			end
			B_OUT: begin
				if (out_load) begin
					out_q.mode     <= mode_q;
					out_q.value    <= val_q;
					out_q.negative <= neg_q;
					for (int i = 0; i < NUM_DIGITS; i++) begin
						out_q.digits[i] <= dig_q[i];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* src/airspeed_temperature_readout_top.sv */
// Top level of the airspeed / temperature readout: configuration registers,
// front end, item queue and back end. Depends on atr_pkg, atr_front, atr_fifo, atr_back.
//
//   channel   handshake          payload
//   input     push / full        operation, sample
//   result    empty / pop        mode, display_value, is_negative, digit_ones .. _thousands
//   config    cfg_we             cfg_index, cfg_data
//
// A temperature item, or an airspeed item with a low sample, goes straight to the digit
// splitter and output state of the back end; an airspeed item first passes the reciprocal
// multiply (MUL, then ADD) and the square root that settles one root bit a cycle.
// The front takes an item each cycle while the two-entry queue has room.
// Reset clears counter, latched sample and queue and selects airspeed mode; no sweep.
// A result not popped stalls the back end; the queue then fills and raises full.
`timescale 1ns / 1ps

module airspeed_temperature_readout_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              operation,
	input  logic [atr_pkg::SAMPLE_BITS-1:0]   sample,
	output logic                              empty,
	input  logic                              pop,
	output logic                              mode,
	output logic [atr_pkg::VAL_BITS-1:0]      display_value,
	output logic                              is_negative,
	output logic [atr_pkg::DIGIT_BITS-1:0]    digit_ones,
	output logic [atr_pkg::DIGIT_BITS-1:0]    digit_tens,
	output logic [atr_pkg::DIGIT_BITS-1:0]    digit_hundreds,
	output logic [atr_pkg::DIGIT_BITS-1:0]    digit_thousands,
	input  logic                              cfg_we,
	input  logic [atr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [atr_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import atr_pkg::*;

	logic [RELOAD_BITS-1:0] tick_reload_q;
	logic [OFFSET_BITS-1:0] temp_offset_q;
	logic                   fifo_push;
	item_t                  fifo_wr_item;
	logic                   fifo_full;
	logic                   fifo_pop;
	item_t                  fifo_rd_item;
	logic                   fifo_empty;
	result_t                result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_reload_q <= RELOAD_RESET;
			temp_offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_TICK_RELOAD: tick_reload_q <= cfg_data[RELOAD_BITS-1:0];
				REG_TEMP_OFFSET: temp_offset_q <= cfg_data[OFFSET_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	atr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.operation   (op_t'(operation)),
		.sample      (sample),
		.tick_reload (tick_reload_q),
		.fifo_full   (fifo_full),
		.fifo_push   (fifo_push),
		.fifo_item   (fifo_wr_item)
	);

	atr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fifo_push),
		.wr_item (fifo_wr_item),
		.full    (fifo_full),
		.rd_en   (fifo_pop),
		.rd_item (fifo_rd_item),
		.empty   (fifo_empty)
	);

	atr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.temp_offset (temp_offset_q),
		.fifo_empty  (fifo_empty),
		.fifo_item   (fifo_rd_item),
		.fifo_pop    (fifo_pop),
		.pop         (pop),
		.empty       (empty),
		.result      (result)
	);

	assign full            = fifo_full;
	assign mode            = result.mode;
	assign display_value   = result.value;
	assign is_negative     = result.negative;
	assign digit_ones      = result.digits[0];
	assign digit_tens      = result.digits[1];
	assign digit_hundreds  = result.digits[2];
	assign digit_thousands = result.digits[3];

endmodule
